>>> rtl/rfr_pkg.sv
// Shared types, constants and helper functions for the radio frame receive filter relay.
// No dependencies; every other file in rtl/ uses it by scoped names.
package rfr_pkg;

    localparam int FRAME_LEN   = 8;
    localparam int RELAY_COUNT = 4;
    localparam int SRC_POS     = 2;
    localparam int DST_POS     = 1;

    localparam int BYTE_W      = 8;
    localparam int FRAME_W     = 64;
    localparam int RELAY_SLOTS = 4;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int RIDX_W      = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] ENC_OFF  = 2'd0;
    localparam logic [1:0] ENC_FULL = 2'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_RELAY   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_ADDRS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ADDR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd5;

    typedef struct packed {
        logic [7:0]  network_id;
        logic [1:0]  enc_mode;
        logic [63:0] key_bytes;
        logic [31:0] relay_addrs;
        logic [7:0]  broadcast_addr;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] data;
    } frame_word_t;

    // per-byte XOR mask for the current mode; bytes past the frame are zero
    function automatic logic [FRAME_W-1:0] key_mask(input logic [63:0] key,
                                                    input logic [1:0] mode);
        logic [FRAME_W-1:0] m;
        m = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if ((i == 0) ? (mode == ENC_FULL) : (mode != ENC_OFF)) begin
                m[i*BYTE_W +: BYTE_W] = key[i*BYTE_W +: BYTE_W];
            end
        end
        return m;
    endfunction

    function automatic logic [BYTE_W-1:0] relay_at(input logic [31:0] relays,
                                                   input int idx);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < RELAY_SLOTS; i++) begin
            if (i == idx) begin
                r = relays[i*BYTE_W +: BYTE_W];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/rfr_rx_front.sv
// Receive front end: byte assembly, descrambling, timeout and network id filter.
// Depends on rfr_pkg; feeds completed plaintext frames to rfr_frame_fifo.
module rfr_rx_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rfr_pkg::cfg_t               cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // rx_byte
    input  logic [0:0]                  s_tuser,   // command
    input  logic                        q_full,
    output rfr_pkg::frame_word_t        q_push
);

    logic [rfr_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]                 tmo_reg, tmo_next;
    logic [rfr_pkg::BYTE_W-1:0]  fbuf_reg [rfr_pkg::FRAME_LEN];
    logic [rfr_pkg::FRAME_W-1:0] mask;
    logic [rfr_pkg::BYTE_W-1:0]  rx;
    logic [rfr_pkg::FRAME_W-1:0] frame;
    logic                        accept, is_byte, complete;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_byte  = (s_tuser[0] == rfr_pkg::CMD_BYTE);
    assign complete = (pos_reg == rfr_pkg::POS_W'(rfr_pkg::FRAME_LEN - 1));
    assign mask     = rfr_pkg::key_mask(cfg.key_bytes, cfg.enc_mode);
    assign rx       = s_tdata ^ mask[pos_reg*rfr_pkg::BYTE_W +: rfr_pkg::BYTE_W];

    always_comb begin
        frame = '0;
        for (int i = 0; i < rfr_pkg::FRAME_LEN; i++) begin
            frame[i*rfr_pkg::BYTE_W +: rfr_pkg::BYTE_W] =
                (i == rfr_pkg::FRAME_LEN - 1) ? rx : fbuf_reg[i];
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        tmo_next    = tmo_reg;
        q_push.valid = 1'b0;
        q_push.data  = frame;
        if (accept) begin
            if (!is_byte) begin
                if (tmo_reg == '0) begin
                    pos_next = '0;
                end else begin
                    tmo_next = tmo_reg - 16'd1;
                end
            end else if (complete) begin
                pos_next     = '0;
                q_push.valid = (frame[rfr_pkg::BYTE_W-1:0] == cfg.network_id);
            end else begin
                pos_next = pos_reg + rfr_pkg::POS_W'(1);
                if (pos_reg == '0) begin
                    tmo_next = cfg.timeout_ticks;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            tmo_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            tmo_reg <= tmo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_byte) begin
            fbuf_reg[pos_reg] <= rx;
        end
    end

endmodule

>>> rtl/rfr_frame_fifo.sv
// Short frame queue between the receive front end and the relay back end.
// Depends on rfr_pkg for depth and word type.
module rfr_frame_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rfr_pkg::frame_word_t        push,
    output logic                        full,
    input  logic                        pop,
    output rfr_pkg::frame_word_t        head
);

    logic [rfr_pkg::FRAME_W-1:0] mem_reg [rfr_pkg::QUEUE_DEPTH];
    logic [rfr_pkg::QPTR_W-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [rfr_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    assign full       = (cnt_reg == rfr_pkg::QCNT_W'(rfr_pkg::QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.data  = mem_reg[rd_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    function automatic logic [rfr_pkg::QPTR_W-1:0] ptr_inc(
            input logic [rfr_pkg::QPTR_W-1:0] p);
        return (p == rfr_pkg::QPTR_W'(rfr_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + rfr_pkg::QPTR_W'(1);
    endfunction

    always_comb begin
        wr_next  = do_push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = do_pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + rfr_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - rfr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push.data;
        end
    end

endmodule

>>> rtl/rfr_relay_back.sv
// Relay back end: emits the delivery word, then scans relays and emits retransmits.
// Depends on rfr_pkg; pulls frames from rfr_frame_fifo and drives the result channel.
module rfr_relay_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rfr_pkg::cfg_t               cfg,
    input  rfr_pkg::frame_word_t        q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // frame_data
    output logic [0:0]                  m_tuser,   // kind
    output logic                        m_tlast
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DELIVER = 2'd1;
    localparam logic [1:0] ST_RELAY   = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [rfr_pkg::RIDX_W-1:0]  idx_reg, idx_next;
    logic [rfr_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic                        vld_reg, vld_next;
    logic [rfr_pkg::FRAME_W-1:0] data_reg, data_next;
    logic                        kind_reg, kind_next;
    logic                        last_reg, last_next;

    logic [rfr_pkg::BYTE_W-1:0]  src, dst, r, new_dst;
    logic [rfr_pkg::FRAME_W-1:0] frame_new;
    logic                        slot_free, match_cur;

    // true when some relay at or after index lo would match with destination d
    function automatic logic any_from(input int lo, input logic [7:0] s,
                                      input logic [7:0] d, input rfr_pkg::cfg_t c);
        logic       hit;
        logic [7:0] rj;
        hit = 1'b0;
        for (int j = 0; j < rfr_pkg::RELAY_COUNT; j++) begin
            rj = rfr_pkg::relay_at(c.relay_addrs, j);
            if (j >= lo && rj != '0 &&
                (s == rj || d == rj || d == c.broadcast_addr)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    assign src       = frame_reg[rfr_pkg::SRC_POS*rfr_pkg::BYTE_W +: rfr_pkg::BYTE_W];
    assign dst       = frame_reg[rfr_pkg::DST_POS*rfr_pkg::BYTE_W +: rfr_pkg::BYTE_W];
    assign r         = rfr_pkg::relay_at(cfg.relay_addrs, int'(idx_reg));
    assign match_cur = (r != '0) && (src == r || dst == r || dst == cfg.broadcast_addr);
    assign new_dst   = (dst == cfg.broadcast_addr && src != r) ? r : dst;
    assign slot_free = !vld_reg || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && q_head.valid;

    always_comb begin
        frame_new = frame_reg;
        frame_new[rfr_pkg::DST_POS*rfr_pkg::BYTE_W +: rfr_pkg::BYTE_W] = new_dst;
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        frame_next = frame_reg;
        vld_next   = vld_reg && !m_tready;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    frame_next = q_head.data;
                    idx_next   = '0;
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (slot_free) begin
                    vld_next   = 1'b1;
                    data_next  = frame_reg;
                    kind_next  = rfr_pkg::KIND_DELIVER;
                    last_next  = !any_from(0, src, dst, cfg);
                    state_next = last_next ? ST_IDLE : ST_RELAY;
                end
            end
            ST_RELAY: begin
                if (slot_free) begin
                    idx_next = idx_reg + rfr_pkg::RIDX_W'(1);
                    if (match_cur) begin
                        vld_next   = 1'b1;
                        data_next  = frame_new ^
                                     rfr_pkg::key_mask(cfg.key_bytes, cfg.enc_mode);
                        kind_next  = rfr_pkg::KIND_RELAY;
                        last_next  = !any_from(int'(idx_reg) + 1, src, new_dst, cfg);
                        frame_next = frame_new;
                        if (last_next) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        frame_reg <= frame_next;
        data_reg  <= data_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
    end

    assign m_tvalid   = vld_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = kind_reg;
    assign m_tlast    = last_reg;

endmodule

>>> rtl/radio_frame_receive_filter_relay_top.sv
// Top level of the radio frame receive filter relay: configuration registers and wiring.
// Depends on rfr_pkg, rfr_rx_front, rfr_frame_fifo and rfr_relay_back.
//
// Each input word (a received byte or a timer tick) is taken while the two-entry
// frame queue has room; s_tready drops only when both entries hold frames.
// A completed frame whose id byte matches is fetched by the back end when it is idle;
// it then emits the delivery word and scans the relays in index order, emitting one
// retransmit word for each match and stopping after the final match. Any output
// stall holds the back end until the pending result word is taken.
// The last result word of a frame carries m_tlast. The configuration channel is always
// ready; writes to indexes beyond the register list are ignored.
module radio_frame_receive_filter_relay_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    input  logic [0:0]  s_tuser,    // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // frame_data[63:0]
    output logic [0:0]  m_tuser,    // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    rfr_pkg::cfg_t        cfg_reg;
    rfr_pkg::frame_word_t q_push, q_head;
    logic                 q_full, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.network_id     <= 8'd0;
            cfg_reg.enc_mode       <= rfr_pkg::ENC_OFF;
            cfg_reg.key_bytes      <= 64'd0;
            cfg_reg.relay_addrs    <= 32'd0;
            cfg_reg.broadcast_addr <= 8'd255;
            cfg_reg.timeout_ticks  <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rfr_pkg::REG_NETWORK_ID:     cfg_reg.network_id     <= cfg_data[7:0];
                rfr_pkg::REG_ENC_MODE:       cfg_reg.enc_mode       <= cfg_data[1:0];
                rfr_pkg::REG_KEY_BYTES:      cfg_reg.key_bytes      <= cfg_data;
                rfr_pkg::REG_RELAY_ADDRS:    cfg_reg.relay_addrs    <= cfg_data[31:0];
                rfr_pkg::REG_BROADCAST_ADDR: cfg_reg.broadcast_addr <= cfg_data[7:0];
                rfr_pkg::REG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks  <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    rfr_rx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    rfr_frame_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    rfr_relay_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.valid)
        else $error("frame queue popped while empty");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result or queue state survived reset");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> !q_full)
        else $error("completed frame pushed into a full queue");
`endif

endmodule
